[sv/plyvx_pkg.sv]
// ----------------------------------------------------------------------------
// plyvx_pkg: shared types and constants for the PLY vertex record extractor
// Register indexes, point record type, binary32 multiply helpers.
// ----------------------------------------------------------------------------
package plyvx_pkg;

	localparam int RegIdxW = 3;
	localparam logic [RegIdxW-1:0] REG_RECORD_LENGTH = 3'd0;
	localparam logic [RegIdxW-1:0] REG_X_OFFSET      = 3'd1;
	localparam logic [RegIdxW-1:0] REG_Y_OFFSET      = 3'd2;
	localparam logic [RegIdxW-1:0] REG_Z_OFFSET      = 3'd3;
	localparam logic [RegIdxW-1:0] REG_COLOR_OFFSETS = 3'd4;
	localparam logic [RegIdxW-1:0] REG_FORMAT_FLAGS  = 3'd5;
	localparam logic [RegIdxW-1:0] REG_SCALE         = 3'd6;
	localparam logic [RegIdxW-1:0] REG_POINT_COUNT   = 3'd7;

	localparam int CfgW = 32;
	localparam int QueueDepth = 4;
	localparam logic [31:0] QNAN = 32'h7FC00000;

	// captured record handed from front to back
	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [31:0] scale;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic        last;
	} rec_t;

	// unpacked operand after first multiply stage
	typedef struct packed {
		logic        sign;
		logic        nan;
		logic        inf;
		logic        zero;
		logic signed [10:0] exp;   // unbiased-ish exponent sum, biased form
		logic [47:0] prod;
	} fmul_mid_t;

	function automatic logic [4:0] lzc24(input logic [23:0] v);
		logic [4:0] n;
		logic       found;
		n = 5'd0;
		found = 1'b0;
		for (int i = 23; i >= 0; i--) begin
			if (!found && v[i]) begin
				found = 1'b1;
				n = 5'(23 - i);
			end
		end
		return found ? n : 5'd24;
	endfunction

endpackage

[sv/plyvx_front.sv]
// ----------------------------------------------------------------------------
// plyvx_front: byte sequencer and record capture
// Tracks position in the record, fills capture words, issues one record
// per completed vertex into the queue.
// ----------------------------------------------------------------------------
module plyvx_front import plyvx_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  in_byte,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  record_length,
	input  logic [7:0]  x_offset,
	input  logic [7:0]  y_offset,
	input  logic [7:0]  z_offset,
	input  logic [23:0] color_offsets,
	input  logic [1:0]  format_flags,
	input  logic [31:0] scale,
	input  logic [31:0] point_count,
	output rec_t        rec,
	output logic        rec_valid,
	input  logic        rec_ready
);

	logic [7:0]  pos_q;
	logic [31:0] done_q;
	logic [31:0] x_q, y_q, z_q;
	logic [23:0] col_q;
	logic [31:0] x_n, y_n, z_n;
	logic [23:0] col_n;
	logic        active, is_end, take;

	function automatic logic [31:0] lane_put(input logic [31:0] w, input logic [7:0] p,
		input logic [7:0] off, input logic [7:0] b, input logic swap);
		logic [7:0]  k;
		logic [1:0]  l;
		logic [31:0] r;
		k = p - off;
		l = swap ? 2'(3 - k[1:0]) : k[1:0];
		r = w;
		if (p >= off && k < 8'd4)
			r[l*8 +: 8] = b;
		return r;
	endfunction

	assign active = done_q < point_count;
	assign is_end = pos_q == 8'(record_length - 8'd1);
	// an idle (done) byte is simply consumed
	assign in_ready = !active || !is_end || rec_ready;
	assign take = in_valid && in_ready && active;

	always_comb begin
		x_n = lane_put(x_q, pos_q, x_offset, in_byte, format_flags[0]);
		y_n = lane_put(y_q, pos_q, y_offset, in_byte, format_flags[0]);
		z_n = lane_put(z_q, pos_q, z_offset, in_byte, format_flags[0]);
		col_n = col_q;
		for (int c = 0; c < 3; c++) begin
			if (pos_q == color_offsets[c*8 +: 8])
				col_n[c*8 +: 8] = in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			done_q <= '0;
			x_q <= '0;
			y_q <= '0;
			z_q <= '0;
			col_q <= '0;
		end else if (take) begin
			x_q <= x_n;
			y_q <= y_n;
			z_q <= z_n;
			col_q <= col_n;
			if (is_end) begin
				pos_q <= '0;
				done_q <= done_q + 32'd1;
			end else begin
				pos_q <= pos_q + 8'd1;
			end
		end
	end

	assign rec_valid = take && is_end;
	always_comb begin
		rec.x = x_n;
		rec.y = y_n;
		rec.z = z_n;
		rec.scale = scale;
		rec.red   = format_flags[1] ? col_n[7:0]   : 8'hFF;
		rec.green = format_flags[1] ? col_n[15:8]  : 8'hFF;
		rec.blue  = format_flags[1] ? col_n[23:16] : 8'hFF;
		rec.last = (done_q + 32'd1) == point_count;
	end

endmodule

[sv/plyvx_queue.sv]
// ----------------------------------------------------------------------------
// plyvx_queue: small record FIFO between front and back
// Register-based FIFO; full/empty from an occupancy count.
// ----------------------------------------------------------------------------
module plyvx_queue import plyvx_pkg::*; #(
	parameter int Depth = QueueDepth
) (
	input  logic clk,
	input  logic arst_n,
	input  rec_t wr_data,
	input  logic wr_valid,
	output logic wr_ready,
	output rec_t rd_data,
	output logic rd_valid,
	input  logic rd_ready
);

	localparam int AW = $clog2(Depth);

	rec_t          mem_q [Depth];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;
	logic          wr, rd;

	assign wr_ready = cnt_q != (AW+1)'(Depth);
	assign rd_valid = cnt_q != '0;
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr)
				wp_q <= (wp_q == AW'(Depth-1)) ? '0 : wp_q + AW'(1);
			if (rd)
				rp_q <= (rp_q == AW'(Depth-1)) ? '0 : rp_q + AW'(1);
			if (wr && !rd)
				cnt_q <= cnt_q + (AW+1)'(1);
			else if (rd && !wr)
				cnt_q <= cnt_q - (AW+1)'(1);
		end
	end

endmodule

[sv/plyvx_fmul.sv]
// ----------------------------------------------------------------------------
// plyvx_fmul: pipelined binary32 multiplier, round to nearest even
// s1: unpack and 24x24 multiply; s2: normalise, round, pack.
// Subnormals in and out handled; NaN results give the quiet pattern.
// ----------------------------------------------------------------------------
module plyvx_fmul import plyvx_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] r
);

	fmul_mid_t m_s1;
	logic [31:0] r_s2;

	// stage 1
	always_ff @(posedge clk) begin
		if (en) begin
			logic [7:0]  ea, eb;
			logic [23:0] ma, mb;
			logic        za, zb, ia, ib, na, nb;
			logic [4:0]  la, lb;
			logic signed [10:0] xa, xb;
			ea = a[30:23];
			eb = b[30:23];
			za = ea == 8'd0 && a[22:0] == '0;
			zb = eb == 8'd0 && b[22:0] == '0;
			ia = ea == 8'hFF && a[22:0] == '0;
			ib = eb == 8'hFF && b[22:0] == '0;
			na = ea == 8'hFF && a[22:0] != '0;
			nb = eb == 8'hFF && b[22:0] != '0;
			ma = {ea != 8'd0, a[22:0]};
			mb = {eb != 8'd0, b[22:0]};
			xa = (ea == 8'd0) ? 11'sd1 : $signed({3'b0, ea});
			xb = (eb == 8'd0) ? 11'sd1 : $signed({3'b0, eb});
			la = lzc24(ma);
			lb = lzc24(mb);
			// pre-normalise subnormals
			ma = ma << la;
			mb = mb << lb;
			xa = xa - $signed({6'b0, la});
			xb = xb - $signed({6'b0, lb});
			m_s1.sign <= a[31] ^ b[31];
			m_s1.nan  <= na || nb || (ia && zb) || (za && ib);
			m_s1.inf  <= ia || ib;
			m_s1.zero <= za || zb;
			m_s1.exp  <= xa + xb - 11'sd127;
			m_s1.prod <= ma * mb;
		end
	end

	// stage 2
	always_ff @(posedge clk) begin
		if (en) begin
			logic [47:0] p;
			logic signed [10:0] e;
			logic [26:0] sig;   // 24 bits + guard + round + sticky
			logic [11:0] sh;
			logic [24:0] rnd;
			logic        st;
			logic [7:0]  eo;
			p = m_s1.prod;
			e = m_s1.exp;
			if (p[47])
				e = e + 11'sd1;
			else
				p = p << 1;
			// p[47] is leading one, value = 1.p * 2^(e-127)
			sig = {p[47:22], |p[21:0]};
			if (e < 11'sd1) begin
				sh = 12'(11'sd1 - e);
				if (sh > 12'd26) begin
					st = |sig;
					sig = {26'b0, st};
				end else begin
					st = |(sig & ((27'd1 << sh[4:0]) - 27'd1));
					sig = (sig >> sh[4:0]) | {26'b0, st};
				end
				e = 11'sd0;
			end
			rnd = {1'b0, sig[26:3]} +
				25'(sig[2] && (sig[1] || sig[0] || sig[3]));
			if (e == 11'sd0) begin
				eo = rnd[23] ? 8'd1 : 8'd0;
			end else if (rnd[24]) begin
				rnd = rnd >> 1;
				e = e + 11'sd1;
				eo = e[7:0];
			end else begin
				eo = e[7:0];
			end
			if (m_s1.nan)
				r_s2 <= QNAN;
			else if (m_s1.inf)
				r_s2 <= {m_s1.sign, 8'hFF, 23'b0};
			else if (m_s1.zero)
				r_s2 <= {m_s1.sign, 31'b0};
			else if (e >= 11'sd255)
				r_s2 <= {m_s1.sign, 8'hFF, 23'b0};
			else
				r_s2 <= {m_s1.sign, eo, rnd[22:0]};
		end
	end

	assign r = r_s2;

endmodule

[sv/plyvx_back.sv]
// ----------------------------------------------------------------------------
// plyvx_back: scaling pipeline and output register
// Three multipliers in lockstep; a 2-stage pipe with valid bits, stalled as
// a whole when the output register is held.
// ----------------------------------------------------------------------------
module plyvx_back import plyvx_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  rec_t         rec,
	input  logic         rec_valid,
	output logic         rec_ready,
	output logic [119:0] tdata,
	output logic         tlast,
	output logic         tvalid,
	input  logic         tready
);

	logic        v_s1, v_s2;
	logic [23:0] col_s1, col_s2;
	logic        last_s1, last_s2;
	logic [31:0] xr, yr, zr;
	logic        adv;

	assign adv = !v_s2 || !tvalid || tready;
	assign rec_ready = adv;
	assign tvalid = v_s2;

	plyvx_fmul u_mx (.clk, .en(adv), .a(rec.x), .b(rec.scale), .r(xr));
	plyvx_fmul u_my (.clk, .en(adv), .a(rec.y), .b(rec.scale), .r(yr));
	plyvx_fmul u_mz (.clk, .en(adv), .a(rec.z), .b(rec.scale), .r(zr));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= rec_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			col_s1 <= {rec.blue, rec.green, rec.red};
			last_s1 <= rec.last;
			col_s2 <= col_s1;
			last_s2 <= last_s1;
		end
	end

	assign tdata = {col_s2, zr, yr, xr};
	assign tlast = last_s2;

endmodule

[sv/ply_vertex_record_extractor.sv]
// ----------------------------------------------------------------------------
// ply_vertex_record_extractor: binary PLY vertex record decoder
// Bytes in, one scaled point with colour out per record.
//
//   channel | dir | payload
//   s_axis  | in  | tdata[7:0] data_byte
//   m_axis  | out | tdata x,y,z,red,green,blue; tlast last_point
//   cfg     | in  | cfg_we / cfg_index / cfg_data
//
// One byte per cycle until a stalled output fills the 4-entry queue; then
// s_axis_tready is held low only on a record's last byte. A point enters the
// queue with its last byte and raises tvalid after multiplier stages s1 and s2
// when nothing waits ahead of it. Reset clears position, count and captures.
// ----------------------------------------------------------------------------
module ply_vertex_record_extractor import plyvx_pkg::*; #(
	parameter int QDepth = QueueDepth
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         s_axis_tdata,   // data_byte
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	output logic [119:0]       m_axis_tdata,   // x_bits,y_bits,z_bits,red,green,blue
	output logic               m_axis_tlast,   // last_point
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	input  logic               cfg_we,
	input  logic [RegIdxW-1:0] cfg_index,
	input  logic [CfgW-1:0]    cfg_data
);

	logic [7:0]  rl_q, xo_q, yo_q, zo_q;
	logic [23:0] co_q;
	logic [1:0]  ff_q;
	logic [31:0] sc_q, pc_q;
	rec_t        f_rec, q_rec;
	logic        f_v, f_r, q_v, q_r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rl_q <= 8'd15;
			xo_q <= 8'd0;
			yo_q <= 8'd4;
			zo_q <= 8'd8;
			co_q <= 24'd920588;
			ff_q <= 2'd0;
			sc_q <= 32'h3F800000;
			pc_q <= 32'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RECORD_LENGTH: rl_q <= cfg_data[7:0];
				REG_X_OFFSET:      xo_q <= cfg_data[7:0];
				REG_Y_OFFSET:      yo_q <= cfg_data[7:0];
				REG_Z_OFFSET:      zo_q <= cfg_data[7:0];
				REG_COLOR_OFFSETS: co_q <= cfg_data[23:0];
				REG_FORMAT_FLAGS:  ff_q <= cfg_data[1:0];
				REG_SCALE:         sc_q <= cfg_data;
				REG_POINT_COUNT:   pc_q <= cfg_data;
				default: ;
			endcase
		end
	end

	plyvx_front u_front (
		.clk, .arst_n,
		.in_byte(s_axis_tdata), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.record_length(rl_q), .x_offset(xo_q), .y_offset(yo_q), .z_offset(zo_q),
		.color_offsets(co_q), .format_flags(ff_q), .scale(sc_q), .point_count(pc_q),
		.rec(f_rec), .rec_valid(f_v), .rec_ready(f_r)
	);

	plyvx_queue #(.Depth(QDepth)) u_queue (
		.clk, .arst_n,
		.wr_data(f_rec), .wr_valid(f_v), .wr_ready(f_r),
		.rd_data(q_rec), .rd_valid(q_v), .rd_ready(q_r)
	);

	plyvx_back u_back (
		.clk, .arst_n,
		.rec(q_rec), .rec_valid(q_v), .rec_ready(q_r),
		.tdata(m_axis_tdata), .tlast(m_axis_tlast),
		.tvalid(m_axis_tvalid), .tready(m_axis_tready)
	);

endmodule
